// File: hw/rtl/iffx_pkg.sv
package iffx_pkg;

	// Parse phases.
	localparam logic [2:0] PH_FILEHDR   = 3'd0;
	localparam logic [2:0] PH_CHUNKHDR  = 3'd1;
	localparam logic [2:0] PH_PAYLOAD   = 3'd2;
	localparam logic [2:0] PH_PAD       = 3'd3;
	localparam logic [2:0] PH_SKIPCHECK = 3'd4;
	localparam logic [2:0] PH_STOP      = 3'd5;

	// Pending line-end rule after a chunk.
	localparam logic [1:0] SKIP_NONE = 2'd0;
	localparam logic [1:0] SKIP_CRLF = 2'd1;
	localparam logic [1:0] SKIP_CR   = 2'd2;

	// Final status codes.
	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_SHORT   = 2'd1;
	localparam logic [1:0] STAT_NO_FORM = 2'd2;
	localparam logic [1:0] STAT_NO_FTXT = 2'd3;

	localparam logic [31:0] TAG_FORM = 32'h464F524D;
	localparam logic [31:0] TAG_FTXT = 32'h46545854;
	localparam logic [31:0] TAG_CHRS = 32'h43485253;

	localparam logic [7:0]  CHAR_NUL = 8'h00;
	localparam logic [7:0]  CHAR_CR  = 8'h0D;
	localparam logic [7:0]  CHAR_LF  = 8'h0A;
	localparam logic [15:0] PAIR_CRLF = 16'h0D0A;

	localparam int MIN_LEN      = 18;
	localparam int FORM_END_POS = 3;
	localparam int FTXT_END_POS = 11;
	localparam int NO_FORM_POS  = 4;

	localparam logic [3:0] HDR_ID_BYTES = 4'd4;
	localparam logic [3:0] HDR_BYTES    = 4'd8;

	localparam int TOTAL_W = 24;

	typedef struct packed {
		logic                 last_byte;
		logic [TOTAL_W-1:0]   total_length;
		logic [7:0]           byte_value;
	} iffx_item_t;

	typedef struct packed {
		logic [1:0] status;
		logic       done_res;
		logic       text_valid;
		logic [7:0] text_byte;
	} iffx_res_t;

endpackage

// File: hw/rtl/iffx_parser.sv
module iffx_parser #(
	parameter int LENGTH_BITS = 24
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 fire,
	input  iffx_pkg::iffx_item_t item,
	output iffx_pkg::iffx_res_t  res
);

	localparam int TW = (LENGTH_BITS < iffx_pkg::TOTAL_W) ? LENGTH_BITS : iffx_pkg::TOTAL_W;
	localparam int SW = ((LENGTH_BITS > 32) ? LENGTH_BITS : 32) + 2;

	logic [LENGTH_BITS-1:0] pos_q, pos_n;
	logic [2:0]             phase_q, phase_n;
	logic [31:0]            shift_q, shift_n;
	logic [31:0]            remain_q, remain_n;
	logic [2:0]             hcnt_q, hcnt_n;
	logic                   odd_q, odd_n;
	logic                   text_q, text_n;
	logic [15:0]            prev_q, prev_n;
	logic [1:0]             skip_q, skip_n;
	logic [1:0]             err_q, err_n;

	logic [LENGTH_BITS-1:0] total_w;
	logic [7:0]             b;
	logic                   take;
	logic                   hdr_go;
	logic [3:0]             hdr_cnt;
	logic [31:0]            hdr_shift;
	logic [31:0]            rem_dec;
	logic [SW-1:0]          reach;
	logic                   emit;
	logic                   drop;
	logic                   chunk_end;
	logic [1:0]             stat;

	assign b       = item.byte_value;
	assign total_w = LENGTH_BITS'(item.total_length[TW-1:0]);

	always_comb begin
		pos_n     = pos_q;
		phase_n   = phase_q;
		shift_n   = shift_q;
		remain_n  = remain_q;
		hcnt_n    = hcnt_q;
		odd_n     = odd_q;
		text_n    = text_q;
		prev_n    = prev_q;
		skip_n    = skip_q;
		err_n     = err_q;
		emit      = 1'b0;
		hdr_go    = 1'b0;
		hdr_cnt   = {1'b0, hcnt_q};
		hdr_shift = {shift_q[23:0], b};
		rem_dec   = remain_q - 32'(remain_q != 32'd0);
		drop      = 1'b0;
		chunk_end = 1'b0;
		reach     = SW'(pos_q) + SW'(1) + SW'(hdr_shift);
		stat      = iffx_pkg::STAT_OK;

		if (total_w < LENGTH_BITS'(iffx_pkg::MIN_LEN)) begin
			err_n   = iffx_pkg::STAT_SHORT;
			phase_n = iffx_pkg::PH_STOP;
		end
		take = (phase_n != iffx_pkg::PH_STOP) && (pos_q < total_w);

		if (take) begin
			unique case (phase_n)
				iffx_pkg::PH_FILEHDR: begin
					shift_n = hdr_shift;
					if (pos_q == LENGTH_BITS'(iffx_pkg::FORM_END_POS)
						&& hdr_shift != iffx_pkg::TAG_FORM) begin
						err_n   = iffx_pkg::STAT_NO_FORM;
						phase_n = iffx_pkg::PH_STOP;
					end else if (pos_q == LENGTH_BITS'(iffx_pkg::FTXT_END_POS)) begin
						if (hdr_shift != iffx_pkg::TAG_FTXT) begin
							err_n   = iffx_pkg::STAT_NO_FTXT;
							phase_n = iffx_pkg::PH_STOP;
						end else begin
							phase_n = iffx_pkg::PH_CHUNKHDR;
							hcnt_n  = 3'd0;
						end
					end
				end
				iffx_pkg::PH_SKIPCHECK: begin
					drop = (skip_q == iffx_pkg::SKIP_CRLF && b == iffx_pkg::CHAR_NUL)
						|| (skip_q == iffx_pkg::SKIP_CR && b == iffx_pkg::CHAR_LF);
					skip_n  = iffx_pkg::SKIP_NONE;
					phase_n = iffx_pkg::PH_CHUNKHDR;
					hcnt_n  = 3'd0;
					hdr_cnt = 4'd0;
					hdr_go  = !drop;
				end
				iffx_pkg::PH_CHUNKHDR: begin
					hdr_go = 1'b1;
				end
				iffx_pkg::PH_PAYLOAD: begin
					prev_n   = {prev_q[7:0], b};
					remain_n = rem_dec;
					emit     = text_q;
					if (rem_dec == 32'd0) begin
						if (odd_q) begin
							phase_n = iffx_pkg::PH_PAD;
						end else begin
							chunk_end = 1'b1;
						end
					end
				end
				iffx_pkg::PH_PAD: begin
					prev_n    = {prev_q[7:0], b};
					chunk_end = 1'b1;
				end
				default: begin
				end
			endcase
		end

		if (hdr_go) begin
			shift_n = hdr_shift;
			hdr_cnt = hdr_cnt + 4'd1;
			if (hdr_cnt == iffx_pkg::HDR_ID_BYTES) begin
				text_n = (hdr_shift == iffx_pkg::TAG_CHRS);
			end
			if (hdr_cnt == iffx_pkg::HDR_BYTES) begin
				hcnt_n = 3'd0;
				// The whole payload must fit before the end of the buffer.
				if (reach > SW'(total_w)) begin
					phase_n = iffx_pkg::PH_STOP;
				end else if (hdr_shift != 32'd0) begin
					remain_n = hdr_shift;
					odd_n    = hdr_shift[0];
					phase_n  = iffx_pkg::PH_PAYLOAD;
				end
			end else begin
				hcnt_n = hdr_cnt[2:0];
			end
		end

		if (chunk_end) begin
			if (prev_n == iffx_pkg::PAIR_CRLF) begin
				skip_n  = iffx_pkg::SKIP_CRLF;
				phase_n = iffx_pkg::PH_SKIPCHECK;
			end else if (prev_n[7:0] == iffx_pkg::CHAR_CR) begin
				skip_n  = iffx_pkg::SKIP_CR;
				phase_n = iffx_pkg::PH_SKIPCHECK;
			end else begin
				skip_n  = iffx_pkg::SKIP_NONE;
				phase_n = iffx_pkg::PH_CHUNKHDR;
				hcnt_n  = 3'd0;
			end
		end

		if (pos_q != {LENGTH_BITS{1'b1}}) begin
			pos_n = pos_q + LENGTH_BITS'(1);
		end

		if (item.last_byte) begin
			if (err_n != iffx_pkg::STAT_OK) begin
				stat = err_n;
			end else if (phase_n == iffx_pkg::PH_FILEHDR) begin
				stat = (pos_n < LENGTH_BITS'(iffx_pkg::NO_FORM_POS))
					? iffx_pkg::STAT_NO_FORM : iffx_pkg::STAT_NO_FTXT;
			end
		end

		res.text_byte  = emit ? b : 8'd0;
		res.text_valid = emit;
		res.done_res   = item.last_byte;
		res.status     = stat;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			phase_q  <= iffx_pkg::PH_FILEHDR;
			shift_q  <= '0;
			remain_q <= '0;
			hcnt_q   <= '0;
			odd_q    <= 1'b0;
			text_q   <= 1'b0;
			prev_q   <= '0;
			skip_q   <= iffx_pkg::SKIP_NONE;
			err_q    <= iffx_pkg::STAT_OK;
		end else if (fire) begin
			if (item.last_byte) begin
				// A buffer ends here; the next transfer starts a new one.
				pos_q    <= '0;
				phase_q  <= iffx_pkg::PH_FILEHDR;
				shift_q  <= '0;
				remain_q <= '0;
				hcnt_q   <= '0;
				odd_q    <= 1'b0;
				text_q   <= 1'b0;
				prev_q   <= '0;
				skip_q   <= iffx_pkg::SKIP_NONE;
				err_q    <= iffx_pkg::STAT_OK;
			end else begin
				pos_q    <= pos_n;
				phase_q  <= phase_n;
				shift_q  <= shift_n;
				remain_q <= remain_n;
				hcnt_q   <= hcnt_n;
				odd_q    <= odd_n;
				text_q   <= text_n;
				prev_q   <= prev_n;
				skip_q   <= skip_n;
				err_q    <= err_n;
			end
		end
	end

endmodule

// File: hw/rtl/iff_ftxt_text_extractor.sv
// A byte is held in the input register, parsed, and its result registered on output.
// Throughput: one byte per cycle unless the output stalls; the input register and the
// result register let a new byte enter while a finished result waits on the output.
// Bytes that produce no text and are not the last byte of a buffer give no result.
// Reset (arst_n low) empties both registers and returns the parser to the file header.
module iff_ftxt_text_extractor #(
	parameter int LENGTH_BITS = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // [7:0] byte_value, [31:8] total_length
	input  logic        s_axis_tlast,   // last_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // [7:0] text_byte
	output logic [2:0]  m_axis_tuser,   // [0] text_valid, [2:1] status
	output logic        m_axis_tlast    // done_res
);

	logic                 valid_s1;
	iffx_pkg::iffx_item_t item_s1;
	logic                 out_valid_q;
	iffx_pkg::iffx_res_t  res_q;
	iffx_pkg::iffx_res_t  res;
	logic                 advance;
	logic                 fire;

	// The stage moves on whenever the result register is free or being drained.
	assign advance       = !out_valid_q || m_axis_tready;
	assign fire          = valid_s1 && advance;
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			item_s1.byte_value   <= s_axis_tdata[7:0];
			item_s1.total_length <= s_axis_tdata[31:8];
			item_s1.last_byte    <= s_axis_tlast;
		end
	end

	iffx_parser #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= fire && (res.text_valid || res.done_res);
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = res_q.text_byte;
	assign m_axis_tuser  = {res_q.status, res_q.text_valid};
	assign m_axis_tlast  = res_q.done_res;

endmodule
